// ===== sv/smsd_pkg.sv =====
// smsd_pkg: shared widths and defaults for the sample mean / stdev block.
// No dependencies.
package smsd_pkg;

  localparam int unsigned SampleW       = 24;
  localparam int unsigned CountW        = 11;
  localparam int unsigned MaxSamplesDef = 1024;

endpackage

// ===== sv/smsd_if.sv =====
// smsd_in_if / smsd_out_if: valid/ready channels for sample requests and results.
// Depends on smsd_pkg.
interface smsd_in_if;
  import smsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface smsd_out_if;
  import smsd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] mean_value;
  logic [SampleW-1:0] std_deviation;
  logic [CountW-1:0]  sample_count;
  logic               empty_set;
  logic               overflowed;

  modport source (output valid, output mean_value, output std_deviation,
                  output sample_count, output empty_set, output overflowed,
                  input ready);
  modport sink   (input valid, input mean_value, input std_deviation,
                  input sample_count, input empty_set, input overflowed,
                  output ready);
endinterface

// ===== sv/smsd_ram.sv =====
// smsd_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module smsd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/smsd_div.sv =====
// smsd_div: restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module smsd_div #(
  parameter int unsigned DendW = 58,
  parameter int unsigned DsorW = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DendW-1:0] dividend_i,
  input  logic [DsorW-1:0] divisor_i,
  output logic [DendW-1:0] quotient_o,
  output logic             done_o
);

  localparam int unsigned StepW = $clog2(DendW + 1);

  logic [DendW-1:0] work_q, work_d;
  logic [DsorW-1:0] rem_q, rem_d;
  logic [DsorW-1:0] dsor_q, dsor_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DsorW:0]   trial;
  logic [DsorW:0]   diff;
  logic             ge;

  always_comb begin
    trial  = {rem_q, work_q[DendW-1]};
    diff   = trial - {1'b0, dsor_q};
    ge     = (trial >= {1'b0, dsor_q});
    work_d = work_q;
    rem_d  = rem_q;
    dsor_d = dsor_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      dsor_d = divisor_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = {work_q[DendW-2:0], ge};
      rem_d  = ge ? diff[DsorW-1:0] : trial[DsorW-1:0];
      step_d = step_q + 1'b1;
      if (step_q == StepW'(DendW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dsor_q <= dsor_d;
  end

  assign quotient_o = work_q;
  assign done_o     = done_q;

endmodule

// ===== sv/smsd_sqrt.sv =====
// smsd_sqrt: digit-by-digit integer square root, one root bit per cycle.
// No dependencies.
module smsd_sqrt #(
  parameter int unsigned InW = 58
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [InW-1:0]         radicand_i,
  output logic [(InW+1)/2-1:0]   root_o,
  output logic                   done_o
);

  localparam int unsigned RootW = (InW + 1) / 2;
  localparam int unsigned StepW = $clog2(RootW + 1);

  logic [2*RootW-1:0] rad_q, rad_d;
  logic [RootW-1:0]   rem_q, rem_d;
  logic [RootW-1:0]   root_q, root_d;
  logic [StepW-1:0]   step_q, step_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [RootW+1:0]   cur;
  logic [RootW+1:0]   trial;
  logic [RootW+1:0]   diff;
  logic               ge;

  always_comb begin
    cur    = {rem_q, rad_q[2*RootW-1 -: 2]};
    trial  = {root_q, 2'b01};
    diff   = cur - trial;
    ge     = (cur >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = (2*RootW)'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = {rad_q[2*RootW-3:0], 2'b00};
      rem_d  = ge ? diff[RootW-1:0] : cur[RootW-1:0];
      root_d = {root_q[RootW-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == StepW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== sv/sample_mean_stdev.sv =====
// sample_mean_stdev: two-pass mean and population standard deviation of a sample set.
// Depends on smsd_pkg, smsd_if, smsd_ram, smsd_div, smsd_sqrt.
//
// Samples are taken one per cycle while the block is loading and are written into a
// MaxSamples-deep sample RAM and a running sum. A request with last_sample set closes
// the set; the block then stops taking requests until its result is written, which also
// waits while the previous result is still held in the output register. A non-empty set
// takes one divide of the sum by n on the bit-serial divider, one pass reading the RAM
// once per sample through a diff/square/accumulate pipeline, a second divide and a
// bit-serial square root; an empty set skips these. The result sits in an output
// register; a new set starts loading as soon as it is written.
// Samples past MaxSamples are dropped and reported through overflowed.
module sample_mean_stdev #(
  parameter int unsigned MaxSamples = smsd_pkg::MaxSamplesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  smsd_in_if.sink            in_i,
  smsd_out_if.source         out_o
);
  import smsd_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxSamples);
  localparam int unsigned CntW  = $clog2(MaxSamples + 1);
  localparam int unsigned SumW  = SampleW + AddrW;
  localparam int unsigned SqW   = 2 * SampleW + AddrW;
  localparam int unsigned RootW = (SqW + 1) / 2;

  typedef enum logic [2:0] {
    S_LOAD, S_MSTART, S_MEAN, S_PASS, S_VSTART, S_VAR, S_ROOT, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    idx_q, idx_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SqW-1:0]     acc_q, acc_d;
  logic               drop_q, drop_d;
  logic               v1_q, v1_d, v2_q, v3_q;
  logic               out_v_q, out_v_d;

  logic [SampleW-1:0]   mean_q;
  logic [SampleW-1:0]   diff_q;
  logic [2*SampleW-1:0] prod_q;
  logic [SampleW-1:0]   out_mean_q, out_sd_q;
  logic [CountW-1:0]    out_cnt_q;
  logic                 out_empty_q, out_ovf_q;

  logic                 in_acc;
  logic                 mem_we;
  logic [SampleW-1:0]   rdata;
  logic                 div_start, div_done;
  logic [SqW-1:0]       div_dend, div_quo;
  logic                 sqrt_start, sqrt_done;
  logic [RootW-1:0]     root;
  logic                 load_out;

  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc     = in_i.valid && in_i.ready;
  assign div_dend   = (state_q == S_VSTART) ? acc_q : SqW'(sum_q);

  smsd_ram #(.Width(SampleW), .Depth(MaxSamples)) u_smsd_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cnt_q[AddrW-1:0]),
    .wdata_i (in_i.sample),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  smsd_div #(.DendW(SqW), .DsorW(CntW)) u_smsd_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (cnt_q),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  smsd_sqrt #(.InW(SqW)) u_smsd_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (div_quo),
    .root_o     (root),
    .done_o     (sqrt_done)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    sum_d      = sum_q;
    drop_d     = drop_q;
    acc_d      = v3_q ? (acc_q + SqW'(prod_q)) : acc_q;
    v1_d       = 1'b0;
    out_v_d    = out_v_q && !out_o.ready;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    load_out   = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_q < CntW'(MaxSamples)) begin
            mem_we = 1'b1;
            sum_d  = sum_q + SumW'(in_i.sample);
            cnt_d  = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (in_i.last_sample) begin
            state_d = S_MSTART;
          end
        end
      end
      S_MSTART: begin
        idx_d = '0;
        acc_d = '0;
        if (cnt_q == '0) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_done) begin
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        if (idx_q != cnt_q) begin
          v1_d  = 1'b1;
          idx_d = idx_q + 1'b1;
        end else if (!v1_q && !v2_q && !v3_q) begin
          state_d = S_VSTART;
        end
      end
      S_VSTART: begin
        div_start = 1'b1;
        state_d   = S_VAR;
      end
      S_VAR: begin
        if (div_done) begin
          sqrt_start = 1'b1;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sqrt_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_v_q || out_o.ready) begin
          load_out = 1'b1;
          out_v_d  = 1'b1;
          cnt_d    = '0;
          sum_d    = '0;
          drop_d   = 1'b0;
          state_d  = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      acc_q   <= '0;
      drop_q  <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      acc_q   <= acc_d;
      drop_q  <= drop_d;
      v1_q    <= v1_d;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_MEAN && div_done) begin
      mean_q <= div_quo[SampleW-1:0];
    end
    diff_q <= (rdata >= mean_q) ? (rdata - mean_q) : (mean_q - rdata);
    prod_q <= diff_q * diff_q;
    if (load_out) begin
      out_mean_q  <= (cnt_q == '0) ? '0 : mean_q;
      out_sd_q    <= (cnt_q == '0) ? '0 : root[SampleW-1:0];
      out_cnt_q   <= CountW'(cnt_q);
      out_empty_q <= (cnt_q == '0);
      out_ovf_q   <= drop_q;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.mean_value    = out_mean_q;
  assign out_o.std_deviation = out_sd_q;
  assign out_o.sample_count  = out_cnt_q;
  assign out_o.empty_set     = out_empty_q;
  assign out_o.overflowed    = out_ovf_q;

endmodule

// ===== sv/smsd_chk.sv =====
// smsd_chk: port-level checks for sample_mean_stdev, bound to the top level.
// Depends on smsd_pkg and sample_mean_stdev.
module smsd_chk #(
  parameter int unsigned MaxSamples = smsd_pkg::MaxSamplesDef
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_last_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [smsd_pkg::SampleW-1:0] mean_i,
  input logic [smsd_pkg::SampleW-1:0] sd_i,
  input logic [smsd_pkg::CountW-1:0]  count_i,
  input logic                       empty_i,
  input logic                       ovf_i
);
  import smsd_pkg::*;

  // a closing request stops intake while the set is evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("request taken right after a closing sample");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mean_i) && $stable(sd_i)
      && $stable(count_i) && $stable(empty_i) && $stable(ovf_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (empty_i == (count_i == '0)))
    else $error("empty flag disagrees with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && empty_i |-> (mean_i == '0) && (sd_i == '0))
    else $error("empty set with nonzero statistics");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ovf_i |-> (count_i == CountW'(MaxSamples)))
    else $error("overflow reported with store not full");

endmodule

bind sample_mean_stdev smsd_chk #(.MaxSamples(MaxSamples)) u_smsd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last_sample),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .mean_i      (out_o.mean_value),
  .sd_i        (out_o.std_deviation),
  .count_i     (out_o.sample_count),
  .empty_i     (out_o.empty_set),
  .ovf_i       (out_o.overflowed)
);
